/* rtl/assert_macros.svh */
// Assertion macros shared by the dispatcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WSTD_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wstd: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define WSTD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wstd: assertion failed");

`endif

/* rtl/wstd_pkg.sv */
// Types, codes and default sizes shared by the task dispatcher files.
`default_nettype none

package wstd_pkg;

   // Default sizes for the top-level parameters.
   localparam int WORKERS_DEF     = 8;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TASK_BITS_DEF   = 32;

   // Reset value of the active-worker register and the pending ceiling.
   localparam logic [3:0] ACTIVE_RESET = 4'd8;
   localparam logic [7:0] PENDING_MAX  = 8'd255;

   // Request kinds.
   localparam logic [1:0] KIND_SUBMIT = 2'd0;
   localparam logic [1:0] KIND_FETCH  = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;

   // Result status codes.
   typedef enum logic [2:0] {
      STAT_ACCEPTED   = 3'd0,
      STAT_REJECTED   = 3'd1,
      STAT_GRANTED    = 3'd2,
      STAT_NONE       = 3'd3,
      STAT_DONE_ACK   = 3'd4,
      STAT_BAD_WORKER = 3'd5
   } status_type;

   // One request transfer.
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] task_id;
      logic [2:0]  requester;
   } req_type;

   // One result transfer.
   typedef struct packed {
      status_type  status;
      logic [31:0] task_out;
      logic [2:0]  queue_index;
      logic        stolen;
      logic [7:0]  pending_count;
      logic        all_idle;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/wstd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module wstd_ram #(
   parameter int WIDTH = wstd_pkg::TASK_BITS_DEF,
   parameter int DEPTH = wstd_pkg::WORKERS_DEF * wstd_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/wstd_ptr_unit.sv */
// Shared slot-pointer adder: (base + offset - dec) wrapped to the queue depth.
`default_nettype none

module wstd_ptr_unit #(
   parameter int QUEUE_DEPTH = wstd_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic [$clog2(QUEUE_DEPTH)-1:0]   base,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] offset,
   input  wire logic                             dec,
   output logic      [$clog2(QUEUE_DEPTH)-1:0]   sum
);

   localparam int SW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int XW = FW + 1;

   logic [XW-1:0] raw;

   // The raw sum stays below twice the depth, so one subtract wraps it.
   assign raw = XW'(base) + XW'(offset) - XW'(dec);
   assign sum = (raw >= XW'(QUEUE_DEPTH)) ? SW'(raw - XW'(QUEUE_DEPTH)) : SW'(raw);

endmodule

`default_nettype wire

/* rtl/work_stealing_task_dispatcher_top.sv */
// Top level of the work-stealing task dispatcher.
//
// A request is taken when start is high and busy is low; every request gives exactly one
// result, shown for one cycle with rsp_strobe and never held off by the receiver. A done
// request, an unknown kind or a fetch from an inactive worker answers in the cycle after the
// transfer, and busy stays low. A submit passes through the submit state, a fetch served from
// the worker's own queue through the own and read states, and a steal from the k-th queue
// scanned after the worker through the own state, k scan states and the read state (the task
// RAM read is registered). A fetch that finds every active queue empty answers from the own state
// if only one queue is active, else after a scan of one queue per cycle via the single pointer adder.
// The RAM needs no clearing after reset, so requests are taken from the first idle cycle.
`default_nettype none
`include "assert_macros.svh"

module work_stealing_task_dispatcher_top #(
   parameter int WORKERS     = wstd_pkg::WORKERS_DEF,
   parameter int QUEUE_DEPTH = wstd_pkg::QUEUE_DEPTH_DEF,
   parameter int TASK_BITS   = wstd_pkg::TASK_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire wstd_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output wstd_pkg::rsp_type      rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [3:0]        csr_wr_data
);

   localparam int WW    = $clog2(WORKERS);
   localparam int SW    = $clog2(QUEUE_DEPTH);
   localparam int FW    = $clog2(QUEUE_DEPTH + 1);
   localparam int CW    = ((WW > 4) ? WW : 4) + 1;
   localparam int AW    = WW + SW;
   localparam int DEPTH = WORKERS * (2 ** SW);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUBMIT,
      ST_OWN,
      ST_SCAN,
      ST_READ
   } state_type;

   state_type         state_ff, state_in;
   logic [WW-1:0]     q_ff, q_in;
   logic [CW-1:0]     steps_ff, steps_in;
   logic [WW-1:0]     next_ff, next_in;
   logic [7:0]        pending_ff, pending_in;
   logic [TASK_BITS-1:0] task_ff, task_in;
   logic              stolen_ff, stolen_in;
   logic [3:0]        active_ff;
   wstd_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   logic [SW-1:0]     head_ff [WORKERS];
   logic [FW-1:0]     fill_ff [WORKERS];
   logic              qs_we;
   logic [SW-1:0]     head_wr_in;
   logic [FW-1:0]     fill_wr_in;

   logic [CW-1:0]     n_live;
   logic [CW-1:0]     worker_ext;
   logic [WW-1:0]     q_sel;
   logic [SW-1:0]     head_cur;
   logic [FW-1:0]     fill_cur;
   logic [7:0]        pend_inc;
   logic [7:0]        pend_dec;
   logic [FW-1:0]     ptr_b;
   logic              ptr_dec;
   logic [SW-1:0]     ptr_sum;
   logic [SW-1:0]     rd_slot;
   logic              ram_we;
   logic              ram_re;
   logic [AW-1:0]     ram_wr_addr;
   logic [AW-1:0]     ram_rd_addr;
   logic [TASK_BITS-1:0] ram_rd_data;
   logic [63:0]       task_word;

   // Next queue index in round-robin order over the live queues.
   function automatic logic [WW-1:0] wrap_inc(input logic [WW-1:0] v,
                                              input logic [CW-1:0] lim);
      logic [CW-1:0] nxt;
      nxt = CW'(v) + CW'(1);
      return (nxt >= lim) ? '0 : nxt[WW-1:0];
   endfunction

   // Assemble one result word.
   function automatic wstd_pkg::rsp_type make_rsp(input wstd_pkg::status_type st,
                                                  input logic [31:0] tsk,
                                                  input logic [2:0]  qidx,
                                                  input logic        stl,
                                                  input logic [7:0]  pend);
      wstd_pkg::rsp_type r;
      r.status        = st;
      r.task_out      = tsk;
      r.queue_index   = qidx;
      r.stolen        = stl;
      r.pending_count = pend;
      r.all_idle      = (pend == 8'd0);
      return r;
   endfunction

   // Live queue count: zero acts as one, anything above WORKERS as WORKERS.
   always_comb begin
      if (active_ff == 4'd0) begin
         n_live = CW'(1);
      end else if (CW'(active_ff) > CW'(WORKERS)) begin
         n_live = CW'(WORKERS);
      end else begin
         n_live = CW'(active_ff);
      end
   end

   // Operands common to several states.
   assign worker_ext = CW'(req_data.requester);
   assign q_sel      = (CW'(next_ff) < n_live) ? next_ff : '0;
   assign head_cur   = head_ff[q_ff];
   assign fill_cur   = fill_ff[q_ff];
   assign pend_inc   = (pending_ff == wstd_pkg::PENDING_MAX) ? pending_ff : pending_ff + 8'd1;
   assign pend_dec   = (pending_ff == 8'd0) ? pending_ff : pending_ff - 8'd1;
   assign task_word  = 64'(ram_rd_data);

   // The shared pointer adder serves the append slot, the head advance and the back slot.
   wstd_ptr_unit #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ptr (
      .base   (head_cur),
      .offset (ptr_b),
      .dec    (ptr_dec),
      .sum    (ptr_sum)
   );

   // Sequencer: one queue looked at per cycle.
   always_comb begin
      state_in      = state_ff;
      q_in          = q_ff;
      steps_in      = steps_ff;
      next_in       = next_ff;
      pending_in    = pending_ff;
      task_in       = task_ff;
      stolen_in     = stolen_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      qs_we         = 1'b0;
      head_wr_in    = head_cur;
      fill_wr_in    = fill_cur;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ptr_b         = fill_cur;
      ptr_dec       = 1'b0;
      rd_slot       = head_cur;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               task_in   = TASK_BITS'(req_data.task_id);
               stolen_in = 1'b0;
               case (req_data.kind)
                  wstd_pkg::KIND_SUBMIT: begin
                     q_in     = q_sel;
                     next_in  = wrap_inc(q_sel, n_live);
                     state_in = ST_SUBMIT;
                  end
                  wstd_pkg::KIND_FETCH: begin
                     if (worker_ext >= n_live) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in = make_rsp(wstd_pkg::STAT_BAD_WORKER, 32'd0, 3'd0, 1'b0,
                                          pending_ff);
                     end else begin
                        q_in     = worker_ext[WW-1:0];
                        state_in = ST_OWN;
                     end
                  end
                  wstd_pkg::KIND_DONE: begin
                     pending_in    = pend_dec;
                     rsp_strobe_in = 1'b1;
                     rsp_in = make_rsp(wstd_pkg::STAT_DONE_ACK, 32'd0, 3'd0, 1'b0, pend_dec);
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in = make_rsp(wstd_pkg::STAT_BAD_WORKER, 32'd0, 3'd0, 1'b0,
                                       pending_ff);
                  end
               endcase
            end
         end

         // Append to the back of the chosen queue unless it is full.
         ST_SUBMIT: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            if (fill_cur >= FW'(QUEUE_DEPTH)) begin
               rsp_in = make_rsp(wstd_pkg::STAT_REJECTED, 32'd0, 3'(q_ff), 1'b0, pending_ff);
            end else begin
               ram_we     = 1'b1;
               qs_we      = 1'b1;
               fill_wr_in = fill_cur + FW'(1);
               pending_in = pend_inc;
               rsp_in = make_rsp(wstd_pkg::STAT_ACCEPTED, 32'd0, 3'(q_ff), 1'b0, pend_inc);
            end
         end

         // Pop the front of the worker's own queue, or start the victim scan.
         ST_OWN: begin
            if (fill_cur != '0) begin
               ptr_b      = FW'(1);
               qs_we      = 1'b1;
               head_wr_in = ptr_sum;
               fill_wr_in = fill_cur - FW'(1);
               ram_re     = 1'b1;
               rd_slot    = head_cur;
               stolen_in  = 1'b0;
               state_in   = ST_READ;
            end else if (n_live == CW'(1)) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_in = make_rsp(wstd_pkg::STAT_NONE, 32'd0, 3'd0, 1'b0, pending_ff);
            end else begin
               q_in     = wrap_inc(q_ff, n_live);
               steps_in = CW'(1);
               state_in = ST_SCAN;
            end
         end

         // Pop the back of the first nonempty queue after the requester.
         ST_SCAN: begin
            ptr_dec = 1'b1;
            if (fill_cur != '0) begin
               qs_we      = 1'b1;
               fill_wr_in = fill_cur - FW'(1);
               ram_re     = 1'b1;
               rd_slot    = ptr_sum;
               stolen_in  = 1'b1;
               state_in   = ST_READ;
            end else if (steps_ff + CW'(1) >= n_live) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_in = make_rsp(wstd_pkg::STAT_NONE, 32'd0, 3'd0, 1'b0, pending_ff);
            end else begin
               q_in     = wrap_inc(q_ff, n_live);
               steps_in = steps_ff + CW'(1);
            end
         end

         // Task word arrives from the RAM.
         ST_READ: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_in = make_rsp(wstd_pkg::STAT_GRANTED, task_word[31:0], 3'(q_ff), stolen_ff,
                              pending_ff);
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, configuration and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         next_ff       <= '0;
         pending_ff    <= '0;
         active_ff     <= wstd_pkg::ACTIVE_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         next_ff       <= next_in;
         pending_ff    <= pending_in;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
      end
      q_ff      <= q_in;
      steps_ff  <= steps_in;
      task_ff   <= task_in;
      stolen_ff <= stolen_in;
      rsp_ff    <= rsp_in;
   end

   // Per-queue head and fill, updated for the queue under the sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WORKERS; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else if (qs_we) begin
         head_ff[q_ff] <= head_wr_in;
         fill_ff[q_ff] <= fill_wr_in;
      end
   end

   // Task words, one row of slots per queue.
   assign ram_wr_addr = {q_ff, ptr_sum};
   assign ram_rd_addr = {q_ff, rd_slot};

   wstd_ram #(
      .WIDTH (TASK_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (task_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Checks on the sequencer and the result word.
   `WSTD_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe)
   `WSTD_ASSERT_IMPL(a_strobe_when_idle, clock, reset, rsp_strobe, !busy)
   `WSTD_ASSERT_IMPL(a_steal_is_grant, clock, reset, rsp_strobe && rsp_data.stolen, rsp_data.status == wstd_pkg::STAT_GRANTED)
   `WSTD_ASSERT_IMPL(a_idle_flag, clock, reset, rsp_strobe, rsp_data.all_idle == (rsp_data.pending_count == 8'd0))

endmodule

`default_nettype wire

/* dv/work_stealing_task_dispatcher_top_tb.sv */
// Self-checking testbench for the work-stealing task dispatcher, with a queue-mirroring scoreboard.
`timescale 1ns / 100ps

import wstd_pkg::*;

// Keeps its own copy of the worker queues and checks every result transfer in order.
class dispatch_ledger;
   logic [31:0] task_words [WORKERS_DEF][QUEUE_DEPTH_DEF];
   logic [3:0]  head_slot  [WORKERS_DEF];
   logic [4:0]  fill_level [WORKERS_DEF];
   logic [2:0]  rr_queue;
   logic [7:0]  pending;
   logic [3:0]  active_reg;
   rsp_type     awaited_rsp [$];
   int          fail_count;
   int          status_seen [8];
   int          steal_count;
   int          peak_pending;
   int          request_count;

   function new();
      foreach (head_slot[q]) begin
         head_slot[q]  = '0;
         fill_level[q] = '0;
      end
      foreach (status_seen[s]) status_seen[s] = 0;
      rr_queue      = '0;
      pending       = '0;
      active_reg    = ACTIVE_RESET;
      fail_count    = 0;
      steal_count   = 0;
      peak_pending  = 0;
      request_count = 0;
   endfunction

   function void set_active(logic [3:0] value);
      active_reg = value;
   endfunction

   // Zero behaves as one queue and anything above the queue count as all of them.
   function int live_count();
      if (active_reg == 0) return 1;
      if (active_reg > WORKERS_DEF) return WORKERS_DEF;
      return int'(active_reg);
   endfunction

   function int outstanding();
      return awaited_rsp.size();
   endfunction

   // Works out the result of one request and updates the mirrored queues.
   function rsp_type predict_dispatch(req_type r);
      rsp_type res;
      int      lanes;
      int      q;
      int      slot;
      int      step;
      bit      found;
      res        = '0;
      res.status = STAT_BAD_WORKER;
      lanes      = live_count();
      case (r.kind)
         KIND_SUBMIT: begin
            // A stale round-robin pointer falls back to queue zero.
            q        = (rr_queue < lanes) ? int'(rr_queue) : 0;
            rr_queue = (q + 1 >= lanes) ? 3'd0 : 3'(q + 1);
            res.queue_index = 3'(q);
            if (fill_level[q] >= QUEUE_DEPTH_DEF) begin
               res.status = STAT_REJECTED;
            end else begin
               slot = (head_slot[q] + fill_level[q]) % QUEUE_DEPTH_DEF;
               task_words[q][slot] = r.task_id;
               fill_level[q] += 1;
               if (pending != PENDING_MAX) pending += 1;
               res.status = STAT_ACCEPTED;
            end
         end
         KIND_FETCH: begin
            if (r.requester >= lanes) begin
               res.status = STAT_BAD_WORKER;
            end else if (fill_level[r.requester] != 0) begin
               q = int'(r.requester);
               res.task_out    = task_words[q][head_slot[q]];
               head_slot[q]   += 1;
               fill_level[q]  -= 1;
               res.queue_index = 3'(q);
               res.status      = STAT_GRANTED;
            end else begin
               // Own queue empty: scan the other active queues and take from the back.
               res.status = STAT_NONE;
               found      = 1'b0;
               for (step = 1; step < lanes && !found; step++) begin
                  q = (int'(r.requester) + step) % lanes;
                  if (fill_level[q] != 0) begin
                     slot = (head_slot[q] + fill_level[q] - 1) % QUEUE_DEPTH_DEF;
                     fill_level[q]  -= 1;
                     res.task_out    = task_words[q][slot];
                     res.queue_index = 3'(q);
                     res.stolen      = 1'b1;
                     res.status      = STAT_GRANTED;
                     found           = 1'b1;
                  end
               end
            end
         end
         KIND_DONE: begin
            if (pending != 0) pending -= 1;
            res.status = STAT_DONE_ACK;
         end
         default: res.status = STAT_BAD_WORKER;
      endcase
      res.pending_count = pending;
      res.all_idle      = (pending == 0);
      return res;
   endfunction

   // Called for every accepted request transfer.
   function void note_request(req_type r);
      rsp_type want;
      want = predict_dispatch(r);
      awaited_rsp.insert(awaited_rsp.size(), want);
      request_count++;
      status_seen[int'(want.status)]++;
      if (want.stolen) steal_count++;
      if (int'(want.pending_count) > peak_pending) peak_pending = int'(want.pending_count);
   endfunction

   function string describe(rsp_type r);
      return $sformatf("status %0d task %h queue %0d stolen %b pending %0d idle %b",
                       r.status, r.task_out, r.queue_index, r.stolen, r.pending_count,
                       r.all_idle);
   endfunction

   // Only the first ten failures are shown; the rest are counted.
   function void log_failure(string what);
      fail_count++;
      if (fail_count <= 10) $display("[%0t] MISMATCH %s", $time, what);
   endfunction

   // Compares one result transfer with the oldest expectation.
   function void check_result(rsp_type got);
      rsp_type want;
      if (awaited_rsp.size() == 0) begin
         log_failure({"result with no request outstanding: ", describe(got)});
         return;
      end
      want = awaited_rsp[0];
      awaited_rsp.delete(0);
      if (got.status !== want.status || got.task_out !== want.task_out ||
          got.queue_index !== want.queue_index || got.stolen !== want.stolen ||
          got.pending_count !== want.pending_count || got.all_idle !== want.all_idle) begin
         log_failure({"expected ", describe(want), " | got ", describe(got)});
      end
   endfunction

   function void close_out();
      if (awaited_rsp.size() != 0) begin
         $display("%0d results never arrived", awaited_rsp.size());
         fail_count += awaited_rsp.size();
      end
   endfunction
endclass

module work_stealing_task_dispatcher_top_tb;
   localparam int         HALF_PERIOD   = 6;
   localparam int         SETTLE_CYCLES = 16;
   localparam int         DRAIN_LIMIT   = 5000;
   localparam logic [1:0] KIND_UNKNOWN  = 2'd3;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       start       = 1'b0;
   logic       busy;
   req_type    req_data    = '0;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_wr_en   = 1'b0;
   logic [3:0] csr_wr_data = '0;

   int             idle_pct      = 0;
   int             settings_used = 1;
   dispatch_ledger ledger;

   work_stealing_task_dispatcher_top dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Every strobed result is a transfer; the receiver never holds one off.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) ledger.check_result(rsp_data);
   end

   function automatic req_type make_req(logic [1:0] kind, logic [31:0] task_word,
                                        logic [2:0] worker);
      req_type r;
      r.kind      = kind;
      r.task_id   = task_word;
      r.requester = worker;
      return r;
   endfunction

   // Random request; fetches mostly come from active workers.
   function automatic req_type random_req(int submit_w, int fetch_w, int done_w);
      req_type r;
      int      pick;
      int      word_pick;
      pick        = $urandom_range(99);
      word_pick   = $urandom_range(15);
      r.task_id   = $urandom();
      if (word_pick == 0) r.task_id = '0;
      if (word_pick == 1) r.task_id = '1;
      if ($urandom_range(9) == 0) begin
         r.requester = 3'($urandom_range(7));
      end else begin
         r.requester = 3'($urandom_range(ledger.live_count() - 1));
      end
      if (pick < submit_w) begin
         r.kind = KIND_SUBMIT;
      end else if (pick < submit_w + fetch_w) begin
         r.kind = KIND_FETCH;
      end else if (pick < submit_w + fetch_w + done_w) begin
         r.kind = KIND_DONE;
      end else begin
         r.kind = KIND_UNKNOWN;
      end
      return r;
   endfunction

   // Offers one request, with a random gap first, and waits for the transfer.
   task automatic send_request(input req_type item);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      ledger.note_request(item);
   endtask

   // Waits until every expected result has come and the block has gone quiet.
   task automatic settle();
      int guard;
      guard = 0;
      start <= 1'b0;
      while ((ledger.outstanding() != 0 || busy !== 1'b0) && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_active(input logic [3:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      ledger.set_active(value);
      settings_used++;
   endtask

   task automatic run_phase(int count, int idle, int submit_w, int fetch_w, int done_w);
      idle_pct = idle;
      repeat (count) send_request(random_req(submit_w, fetch_w, done_w));
   endtask

   initial begin
      int k;
      ledger = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: underflow, empty fetch, unknown kind, own fetch and a steal.
      idle_pct = 0;
      send_request(make_req(KIND_DONE,    32'h0000_0000, 3'd0));
      send_request(make_req(KIND_FETCH,   32'h0000_0000, 3'd3));
      send_request(make_req(KIND_UNKNOWN, 32'hFFFF_FFFF, 3'd7));
      send_request(make_req(KIND_SUBMIT,  32'hFFFF_FFFF, 3'd7));
      send_request(make_req(KIND_SUBMIT,  32'h0000_0000, 3'd0));
      send_request(make_req(KIND_FETCH,   32'h1234_5678, 3'd0));
      send_request(make_req(KIND_FETCH,   32'h0000_0000, 3'd6));
      send_request(make_req(KIND_SUBMIT,  32'hA5A5_A5A5, 3'd2));
      send_request(make_req(KIND_SUBMIT,  32'h5A5A_5A5A, 3'd5));
      send_request(make_req(KIND_SUBMIT,  32'hDEAD_BEEF, 3'd1));

      // Fewer queues than the round-robin pointer: stale pointer and an inactive worker.
      write_active(4'd3);
      send_request(make_req(KIND_SUBMIT, 32'hC0DE_0001, 3'd4));
      send_request(make_req(KIND_FETCH,  32'h0000_0000, 3'd7));

      // One queue only: fill it to the brim, overflow it, then serve from the front.
      write_active(4'd1);
      for (k = 0; k < QUEUE_DEPTH_DEF; k++) begin
         send_request(make_req(KIND_SUBMIT, 32'h1111_1111 * k, 3'(k)));
      end
      send_request(make_req(KIND_FETCH, 32'h0000_0000, 3'd0));

      // Random phases over several queue counts and sender gap rates.
      write_active(4'd8);
      run_phase(150, 0, 40, 35, 20);
      write_active(4'd1);
      run_phase(150, 55, 60, 25, 10);
      // No done reports here, so the pending count only climbs, up to its ceiling.
      write_active(4'd15);
      run_phase(400, 32, 55, 45, 0);
      write_active(4'(2 + $urandom_range(5)));
      run_phase(350, 55, 5, 15, 78);
      write_active(4'd0);
      run_phase(80, 0, 40, 40, 15);

      settle();
      ledger.close_out();
      $display("Covered %0d requests under %0d queue-count settings: %0d accepted, %0d rejected full, %0d granted (%0d stolen).",
               ledger.request_count, settings_used, ledger.status_seen[STAT_ACCEPTED],
               ledger.status_seen[STAT_REJECTED], ledger.status_seen[STAT_GRANTED],
               ledger.steal_count);
      $display("Also %0d empty fetches, %0d done reports, %0d bad worker or unknown kind; peak pending %0d.",
               ledger.status_seen[STAT_NONE], ledger.status_seen[STAT_DONE_ACK],
               ledger.status_seen[STAT_BAD_WORKER], ledger.peak_pending);
      if (ledger.fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end
endmodule

/* work_stealing_task_dispatcher_top.f */
+incdir+rtl
rtl/wstd_pkg.sv
rtl/wstd_ram.sv
rtl/wstd_ptr_unit.sv
rtl/work_stealing_task_dispatcher_top.sv
dv/work_stealing_task_dispatcher_top_tb.sv
